// ===== sv/tekd_pkg.sv =====
// Shared types, constants and the tilde-code lookup for the terminal escape
// key decoder. No dependencies; used by tekd_parser and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tekd_pkg;

  // Sizing of the CSI collector
  localparam int MaxParams   = 4;
  localparam int SeqMaxBytes = 15;
  localparam int CoordBits   = 12;

  localparam int PcntW = $clog2(MaxParams + 1);
  localparam int PidxW = $clog2(MaxParams);
  localparam int SlenW = $clog2(SeqMaxBytes + 1);
  localparam int ProdW = CoordBits + 4;

  localparam logic [CoordBits-1:0] PvalMax = {CoordBits{1'b1}};

  // Timeout register
  localparam int                 TimeoutW     = 8;
  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd20;
  localparam logic [7:0]          WaitMax      = 8'hFF;

  // Byte codes
  localparam logic [7:0] ByteEsc   = 8'h1B;
  localparam logic [7:0] ByteDel   = 8'h7F;
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteLbr   = 8'h5B; // '['
  localparam logic [7:0] ByteSs3   = 8'h4F; // 'O'
  localparam logic [7:0] ByteSemi  = 8'h3B;
  localparam logic [7:0] ByteLt    = 8'h3C;
  localparam logic [7:0] ByteTilde = 8'h7E;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteNine  = 8'h39;
  localparam logic [7:0] FinalLo   = 8'h40;
  localparam logic [7:0] FinalHi   = 8'h7E;
  localparam logic [7:0] ByteUpA   = 8'h41; // 'A'
  localparam logic [7:0] ByteUpB   = 8'h42;
  localparam logic [7:0] ByteUpC   = 8'h43;
  localparam logic [7:0] ByteUpD   = 8'h44;
  localparam logic [7:0] ByteUpF   = 8'h46;
  localparam logic [7:0] ByteUpH   = 8'h48;
  localparam logic [7:0] ByteUpM   = 8'h4D;
  localparam logic [7:0] ByteUpP   = 8'h50;
  localparam logic [7:0] ByteUpQ   = 8'h51;
  localparam logic [7:0] ByteUpR   = 8'h52;
  localparam logic [7:0] ByteUpS   = 8'h53;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } tekd_op_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_SS3,
    MODE_CSI
  } tekd_mode_e;

  // Kind of the first byte after ESC [
  typedef enum logic [1:0] {
    FB_NONE,
    FB_DIGIT,
    FB_LT,
    FB_OTHER
  } tekd_fbk_e;

  typedef enum logic [4:0] {
    KEY_CHAR  = 5'd0,
    KEY_UP    = 5'd1,
    KEY_DOWN  = 5'd2,
    KEY_RIGHT = 5'd3,
    KEY_LEFT  = 5'd4,
    KEY_HOME  = 5'd5,
    KEY_END   = 5'd6,
    KEY_INS   = 5'd7,
    KEY_DEL   = 5'd8,
    KEY_PGUP  = 5'd9,
    KEY_PGDN  = 5'd10,
    KEY_F1    = 5'd11,
    KEY_F2    = 5'd12,
    KEY_F3    = 5'd13,
    KEY_F4    = 5'd14,
    KEY_F5    = 5'd15,
    KEY_F6    = 5'd16,
    KEY_F7    = 5'd17,
    KEY_F8    = 5'd18,
    KEY_F9    = 5'd19,
    KEY_F10   = 5'd20,
    KEY_F11   = 5'd21,
    KEY_F12   = 5'd22,
    KEY_ESC   = 5'd23,
    KEY_BS    = 5'd24,
    KEY_TAB   = 5'd25,
    KEY_MOUSE = 5'd26
  } tekd_key_e;

  typedef struct packed {
    tekd_key_e            key;
    logic [7:0]           ch;
    logic [1:0]           btn;
    logic                 pressed;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } tekd_result_t;

  // Editing and function keys coded as ESC [ n ~
  function automatic tekd_key_e tilde_key(input logic [CoordBits-1:0] p);
    tekd_key_e k;
    unique case (p)
      CoordBits'(1):  k = KEY_HOME;
      CoordBits'(2):  k = KEY_INS;
      CoordBits'(3):  k = KEY_DEL;
      CoordBits'(4):  k = KEY_END;
      CoordBits'(5):  k = KEY_PGUP;
      CoordBits'(6):  k = KEY_PGDN;
      CoordBits'(11): k = KEY_F1;
      CoordBits'(12): k = KEY_F2;
      CoordBits'(13): k = KEY_F3;
      CoordBits'(14): k = KEY_F4;
      CoordBits'(15): k = KEY_F5;
      CoordBits'(17): k = KEY_F6;
      CoordBits'(18): k = KEY_F7;
      CoordBits'(19): k = KEY_F8;
      CoordBits'(20): k = KEY_F9;
      CoordBits'(21): k = KEY_F10;
      CoordBits'(23): k = KEY_F11;
      CoordBits'(24): k = KEY_F12;
      default:        k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tekd_parser.sv =====
// Escape sequence parser: holds the sequence state and produces at most one
// decoded key per step. Depends on tekd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tekd_parser (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              step_i,
  input  wire                              op_i,
  input  wire [7:0]                        byte_i,
  input  wire [tekd_pkg::TimeoutW-1:0]     timeout_i,
  output logic                             res_valid_o,
  output tekd_pkg::tekd_result_t           res_o
);

  tekd_pkg::tekd_mode_e                  mode_q, mode_d;
  logic [7:0]                            wait_q, wait_d;
  logic [tekd_pkg::SlenW-1:0]            len_q, len_d;
  logic [tekd_pkg::CoordBits-1:0]        pv_q [tekd_pkg::MaxParams];
  logic [tekd_pkg::CoordBits-1:0]        pv_d [tekd_pkg::MaxParams];
  logic [tekd_pkg::PcntW-1:0]            cnt_q, cnt_d;
  tekd_pkg::tekd_fbk_e                   fbk_q, fbk_d;
  logic                                  tda_q, tda_d;
  logic                                  tok_q, tok_d;

  // Shared decode of the incoming byte and tick
  logic                           is_tick, is_digit, is_final, first, do_feed, term;
  logic                           timed_out;
  logic [7:0]                     wait_inc;
  logic [tekd_pkg::TimeoutW-1:0]  thr;
  logic [tekd_pkg::SlenW-1:0]     len_inc;
  tekd_pkg::tekd_fbk_e            fbk_n;

  assign is_tick  = (op_i == tekd_pkg::OP_TICK);
  assign is_digit = (byte_i >= tekd_pkg::ByteZero) && (byte_i <= tekd_pkg::ByteNine);
  assign is_final = (byte_i >= tekd_pkg::FinalLo) && (byte_i <= tekd_pkg::FinalHi);
  assign len_inc  = len_q + tekd_pkg::SlenW'(1);
  assign first    = (len_inc == tekd_pkg::SlenW'(1));
  assign term     = is_final || (len_inc >= tekd_pkg::SlenW'(tekd_pkg::SeqMaxBytes));
  assign wait_inc = (wait_q == tekd_pkg::WaitMax) ? wait_q : wait_q + 8'd1;
  assign thr      = (timeout_i == '0) ? tekd_pkg::TimeoutW'(1) : timeout_i;
  assign timed_out = (wait_inc >= thr);

  always_comb begin
    if (!first) begin
      fbk_n = fbk_q;
    end else if (is_digit) begin
      fbk_n = tekd_pkg::FB_DIGIT;
    end else if (byte_i == tekd_pkg::ByteLt) begin
      fbk_n = tekd_pkg::FB_LT;
    end else begin
      fbk_n = tekd_pkg::FB_OTHER;
    end
  end

  assign do_feed = first ? is_digit
                         : (fbk_q == tekd_pkg::FB_DIGIT || fbk_q == tekd_pkg::FB_LT);

  // Parameter field accumulation: ';' splits, leading digits count, saturating
  logic [tekd_pkg::CoordBits-1:0] pv_f [tekd_pkg::MaxParams];
  logic [tekd_pkg::PcntW-1:0]     cnt_f, cnt_m1;
  logic                           tda_f, tok_f, new_tok;
  logic [tekd_pkg::PidxW-1:0]     idx;
  logic [tekd_pkg::CoordBits-1:0] base;
  logic [tekd_pkg::ProdW-1:0]     prod;

  assign cnt_m1 = cnt_q - tekd_pkg::PcntW'(1);

  always_comb begin
    pv_f    = pv_q;
    cnt_f   = cnt_q;
    tda_f   = tda_q;
    tok_f   = tok_q;
    new_tok = 1'b0;
    if (do_feed && byte_i != tekd_pkg::ByteSemi && !tok_q) begin
      tok_f = 1'b1;
      if (cnt_q < tekd_pkg::PcntW'(tekd_pkg::MaxParams)) begin
        new_tok = 1'b1;
        cnt_f   = cnt_q + tekd_pkg::PcntW'(1);
        tda_f   = 1'b1;
      end else begin
        tda_f = 1'b0;
      end
    end
    idx  = new_tok ? cnt_q[tekd_pkg::PidxW-1:0] : cnt_m1[tekd_pkg::PidxW-1:0];
    base = new_tok ? '0 : pv_q[idx];
    prod = tekd_pkg::ProdW'(base) * tekd_pkg::ProdW'(10)
         + tekd_pkg::ProdW'(byte_i[3:0]);
    if (do_feed) begin
      if (byte_i == tekd_pkg::ByteSemi) begin
        tok_f = 1'b0;
        tda_f = 1'b0;
      end else if (tda_f) begin
        if (is_digit) begin
          pv_f[idx] = (prod > tekd_pkg::ProdW'(tekd_pkg::PvalMax))
                    ? tekd_pkg::PvalMax : prod[tekd_pkg::CoordBits-1:0];
        end else begin
          if (new_tok) begin
            pv_f[idx] = '0;
          end
          tda_f = 1'b0;
        end
      end
    end
  end

  // Next state
  logic clr;

  always_comb begin
    mode_d = mode_q;
    wait_d = wait_q;
    len_d  = len_q;
    pv_d   = pv_q;
    cnt_d  = cnt_q;
    fbk_d  = fbk_q;
    tda_d  = tda_q;
    tok_d  = tok_q;
    clr    = 1'b0;
    if (step_i) begin
      if (is_tick) begin
        if (mode_q != tekd_pkg::MODE_IDLE) begin
          wait_d = wait_inc;
          clr    = timed_out;
        end
      end else begin
        wait_d = '0;
        unique case (mode_q)
          tekd_pkg::MODE_IDLE: begin
            if (byte_i == tekd_pkg::ByteEsc) begin
              mode_d = tekd_pkg::MODE_ESC;
            end
          end
          tekd_pkg::MODE_ESC: begin
            if (byte_i == tekd_pkg::ByteLbr) begin
              mode_d = tekd_pkg::MODE_CSI;
            end else if (byte_i == tekd_pkg::ByteSs3) begin
              mode_d = tekd_pkg::MODE_SS3;
            end else begin
              clr = 1'b1;
            end
          end
          tekd_pkg::MODE_SS3: begin
            clr = 1'b1;
          end
          tekd_pkg::MODE_CSI: begin
            len_d = len_inc;
            fbk_d = fbk_n;
            pv_d  = pv_f;
            cnt_d = cnt_f;
            tda_d = tda_f;
            tok_d = tok_f;
            clr   = term;
          end
          default: begin
            clr = 1'b1;
          end
        endcase
      end
    end
    if (clr) begin
      mode_d = tekd_pkg::MODE_IDLE;
      wait_d = '0;
      len_d  = '0;
      for (int i = 0; i < tekd_pkg::MaxParams; i++) begin
        pv_d[i] = '0;
      end
      cnt_d = '0;
      fbk_d = tekd_pkg::FB_NONE;
      tda_d = 1'b0;
      tok_d = 1'b0;
    end
  end

  // Result
  tekd_pkg::tekd_key_e            tk;
  logic [tekd_pkg::CoordBits-1:0] p0;

  assign p0 = (cnt_f >= tekd_pkg::PcntW'(1)) ? pv_f[0] : '0;
  assign tk = tekd_pkg::tilde_key(p0);

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.key   = tekd_pkg::KEY_ESC;
    if (step_i) begin
      if (is_tick) begin
        res_valid_o = (mode_q != tekd_pkg::MODE_IDLE) && timed_out;
      end else begin
        unique case (mode_q)
          tekd_pkg::MODE_IDLE: begin
            res_valid_o = (byte_i != tekd_pkg::ByteEsc);
            if (byte_i == tekd_pkg::ByteDel) begin
              res_o.key = tekd_pkg::KEY_BS;
            end else if (byte_i == tekd_pkg::ByteTab) begin
              res_o.key = tekd_pkg::KEY_TAB;
            end else begin
              res_o.key = tekd_pkg::KEY_CHAR;
              res_o.ch  = byte_i;
            end
          end
          tekd_pkg::MODE_ESC: begin
            res_valid_o = (byte_i != tekd_pkg::ByteLbr) && (byte_i != tekd_pkg::ByteSs3);
          end
          tekd_pkg::MODE_SS3: begin
            res_valid_o = 1'b1;
            unique case (byte_i)
              tekd_pkg::ByteUpP: res_o.key = tekd_pkg::KEY_F1;
              tekd_pkg::ByteUpQ: res_o.key = tekd_pkg::KEY_F2;
              tekd_pkg::ByteUpR: res_o.key = tekd_pkg::KEY_F3;
              tekd_pkg::ByteUpS: res_o.key = tekd_pkg::KEY_F4;
              tekd_pkg::ByteUpH: res_o.key = tekd_pkg::KEY_HOME;
              tekd_pkg::ByteUpF: res_o.key = tekd_pkg::KEY_END;
              default:           res_o.key = tekd_pkg::KEY_ESC;
            endcase
          end
          tekd_pkg::MODE_CSI: begin
            res_valid_o = term;
            unique case (byte_i)
              tekd_pkg::ByteUpA: res_o.key = tekd_pkg::KEY_UP;
              tekd_pkg::ByteUpB: res_o.key = tekd_pkg::KEY_DOWN;
              tekd_pkg::ByteUpC: res_o.key = tekd_pkg::KEY_RIGHT;
              tekd_pkg::ByteUpD: res_o.key = tekd_pkg::KEY_LEFT;
              tekd_pkg::ByteUpH: res_o.key = tekd_pkg::KEY_HOME;
              tekd_pkg::ByteUpF: res_o.key = tekd_pkg::KEY_END;
              default: begin
                if (byte_i == tekd_pkg::ByteTilde && tk != tekd_pkg::KEY_ESC) begin
                  res_o.key = tk;
                end else if (cnt_f >= tekd_pkg::PcntW'(3) && fbk_n == tekd_pkg::FB_LT) begin
                  res_o.key     = tekd_pkg::KEY_MOUSE;
                  res_o.btn     = pv_f[0][1:0];
                  res_o.pressed = (byte_i == tekd_pkg::ByteUpM);
                  res_o.x       = pv_f[1];
                  res_o.y       = pv_f[2];
                end else begin
                  res_o.key = tekd_pkg::KEY_ESC;
                end
              end
            endcase
          end
          default: begin
            res_valid_o = 1'b1;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tekd_pkg::MODE_IDLE;
      wait_q <= '0;
      len_q  <= '0;
      for (int i = 0; i < tekd_pkg::MaxParams; i++) begin
        pv_q[i] <= '0;
      end
      cnt_q  <= '0;
      fbk_q  <= tekd_pkg::FB_NONE;
      tda_q  <= 1'b0;
      tok_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      wait_q <= wait_d;
      len_q  <= len_d;
      pv_q   <= pv_d;
      cnt_q  <= cnt_d;
      fbk_q  <= fbk_d;
      tda_q  <= tda_d;
      tok_q  <= tok_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/terminal_escape_key_decoder_top.sv =====
// Top level of the terminal escape key decoder: handshakes, timeout register
// and result register. Depends on tekd_pkg and tekd_parser.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    op_i, byte_value_i
//   out      output     out_valid_o / out_stall_i  key_code_o .. mouse_y_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i (esc timeout)
//
// One item per cycle unless stalled; a key appears on the output in the cycle
// after the transfer that completes it, held in a single result register.
// The input is stalled only while that register is full and the output stalled.
// Reset returns the parser to idle and the timeout to 20 ticks.
// Configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module terminal_escape_key_decoder_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                op_i,
  input  wire  [7:0]                         byte_value_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [4:0]                         key_code_o,
  output logic [7:0]                         char_code_o,
  output logic [1:0]                         mouse_button_o,
  output logic                               mouse_pressed_o,
  output logic [tekd_pkg::CoordBits-1:0]     mouse_x_o,
  output logic [tekd_pkg::CoordBits-1:0]     mouse_y_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [tekd_pkg::TimeoutW-1:0]      cfg_data_i
);

  logic [tekd_pkg::TimeoutW-1:0] timeout_q;
  logic                          out_valid_q;
  tekd_pkg::tekd_result_t        res_q;
  tekd_pkg::tekd_result_t        res;
  logic                          res_valid;
  logic                          in_xfer;

  // Input transfer whenever the result register can take a new entry
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  tekd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .op_i        (op_i),
    .byte_i      (byte_value_i),
    .timeout_i   (timeout_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= tekd_pkg::TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_code_o      = res_q.key;
  assign char_code_o     = res_q.ch;
  assign mouse_button_o  = res_q.btn;
  assign mouse_pressed_o = res_q.pressed;
  assign mouse_x_o       = res_q.x;
  assign mouse_y_o       = res_q.y;

endmodule

`default_nettype wire

// ===== tb/sv/terminal_escape_key_decoder_top_tb.sv =====
// Self-checking testbench for terminal_escape_key_decoder_top: bytes and ticks
// are driven, keys are predicted in the bench and compared on the output.
// Depends on tekd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module terminal_escape_key_decoder_top_tb;
  import tekd_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int IdlePct    = 12;
  localparam int HoldCycles = 60;

  typedef struct packed {
    tekd_op_e   op;
    logic [7:0] b;
  } feed_item_t;

  // Clock and DUT signals
  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_op = 1'b0;
  logic [7:0]           in_byte = 8'h00;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [TimeoutW-1:0]  cfg_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 cfg_ready;
  logic [4:0]           key_code;
  logic [7:0]           char_code;
  logic [1:0]           mouse_button;
  logic                 mouse_pressed;
  logic [CoordBits-1:0] mouse_x;
  logic [CoordBits-1:0] mouse_y;

  // Stimulus and scoreboard state
  feed_item_t   byte_feed[$];
  tekd_result_t pending_keys[$];
  int           n_pushed = 0;
  int           n_taken = 0;
  int           n_err = 0;
  int           cycle_cnt = 0;
  int           hold_left = 0;
  int           holds_done = 0;
  bit           in_taken = 1'b0;
  bit           cfg_taken = 1'b0;
  bit           jitter = 1'b0;
  wire          calm = (n_taken >= 60) && (n_taken < 250);

  // Decoder image kept by the bench
  logic [TimeoutW-1:0]  tmo = TimeoutReset;
  tekd_mode_e           mode = MODE_IDLE;
  logic [7:0]           wait_cnt = '0;
  logic [SlenW-1:0]     seq_len = '0;
  logic [CoordBits-1:0] pval[MaxParams];
  logic [PcntW-1:0]     pcnt = '0;
  tekd_fbk_e            fbk = FB_NONE;
  bit                   digits_on = 1'b0;
  bit                   in_field = 1'b0;

  always #1 clk_i = ~clk_i;

  terminal_escape_key_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (in_op),
    .byte_value_i   (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .key_code_o     (key_code),
    .char_code_o    (char_code),
    .mouse_button_o (mouse_button),
    .mouse_pressed_o(mouse_pressed),
    .mouse_x_o      (mouse_x),
    .mouse_y_o      (mouse_y),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void drop_sequence();
    mode      = MODE_IDLE;
    wait_cnt  = '0;
    seq_len   = '0;
    for (int i = 0; i < MaxParams; i++) pval[i] = '0;
    pcnt      = '0;
    fbk       = FB_NONE;
    digits_on = 1'b0;
    in_field  = 1'b0;
  endfunction

  // Semicolon-split decimal fields, saturating, extra fields dropped
  function automatic void take_param_byte(input logic [7:0] b);
    logic [ProdW-1:0] v;
    if (b == ByteSemi) begin
      in_field  = 1'b0;
      digits_on = 1'b0;
      return;
    end
    if (!in_field) begin
      in_field = 1'b1;
      if (pcnt < MaxParams) begin
        pval[pcnt] = '0;
        pcnt++;
        digits_on = 1'b1;
      end else begin
        digits_on = 1'b0;
      end
    end
    if (digits_on) begin
      if (b >= ByteZero && b <= ByteNine) begin
        v = ProdW'(pval[pcnt-1]) * ProdW'(10) + ProdW'(b - ByteZero);
        pval[pcnt-1] = (v > ProdW'(PvalMax)) ? PvalMax : v[CoordBits-1:0];
      end else begin
        digits_on = 1'b0;
      end
    end
  endfunction

  function automatic tekd_key_e tilde_code(input logic [CoordBits-1:0] p);
    if (p >= 1 && p <= 4) return (p == 1) ? KEY_HOME : (p == 2) ? KEY_INS :
                                  (p == 3) ? KEY_DEL : KEY_END;
    if (p == 5) return KEY_PGUP;
    if (p == 6) return KEY_PGDN;
    if (p >= 11 && p <= 15) return tekd_key_e'(KEY_F1 + (p - 11));
    if (p >= 17 && p <= 21) return tekd_key_e'(KEY_F6 + (p - 17));
    if (p >= 23 && p <= 24) return tekd_key_e'(KEY_F11 + (p - 23));
    return KEY_ESC;
  endfunction

  function automatic tekd_result_t csi_final(input logic [7:0] b);
    tekd_result_t r;
    tekd_key_e    k;
    r = '0;
    case (b)
      ByteUpA: r.key = KEY_UP;
      ByteUpB: r.key = KEY_DOWN;
      ByteUpC: r.key = KEY_RIGHT;
      ByteUpD: r.key = KEY_LEFT;
      ByteUpH: r.key = KEY_HOME;
      ByteUpF: r.key = KEY_END;
      default: begin
        k = KEY_ESC;
        if (b == ByteTilde) k = tilde_code((pcnt != 0) ? pval[0] : '0);
        if (k != KEY_ESC) begin
          r.key = k;
        end else if (pcnt >= 3 && fbk == FB_LT) begin
          r.key     = KEY_MOUSE;
          r.btn     = pval[0][1:0];
          r.pressed = (b == ByteUpM);
          r.x       = pval[1];
          r.y       = pval[2];
        end else begin
          r.key = KEY_ESC;
        end
      end
    endcase
    return r;
  endfunction

  // One byte or tick; returns 1 when a key is produced
  function automatic bit decode_key(input tekd_op_e op, input logic [7:0] b,
                                    output tekd_result_t r);
    logic [7:0] thr;
    r = '0;
    if (op == OP_TICK) begin
      thr = (tmo == '0) ? 8'd1 : tmo;
      if (mode == MODE_IDLE) return 1'b0;
      if (wait_cnt != WaitMax) wait_cnt++;
      if (wait_cnt >= thr) begin
        drop_sequence();
        r.key = KEY_ESC;
        return 1'b1;
      end
      return 1'b0;
    end
    wait_cnt = '0;
    case (mode)
      MODE_IDLE: begin
        if (b == ByteEsc) begin
          mode = MODE_ESC;
          return 1'b0;
        end
        if (b == ByteDel) r.key = KEY_BS;
        else if (b == ByteTab) r.key = KEY_TAB;
        else begin
          r.key = KEY_CHAR;
          r.ch  = b;
        end
        return 1'b1;
      end
      MODE_ESC: begin
        if (b == ByteLbr) begin
          mode = MODE_CSI;
          return 1'b0;
        end
        if (b == ByteSs3) begin
          mode = MODE_SS3;
          return 1'b0;
        end
        drop_sequence();
        r.key = KEY_ESC;
        return 1'b1;
      end
      MODE_SS3: begin
        case (b)
          ByteUpP: r.key = KEY_F1;
          ByteUpQ: r.key = KEY_F2;
          ByteUpR: r.key = KEY_F3;
          ByteUpS: r.key = KEY_F4;
          ByteUpH: r.key = KEY_HOME;
          ByteUpF: r.key = KEY_END;
          default: r.key = KEY_ESC;
        endcase
        drop_sequence();
        return 1'b1;
      end
      default: begin
        seq_len++;
        if (seq_len == 1) begin
          if (b >= ByteZero && b <= ByteNine) fbk = FB_DIGIT;
          else if (b == ByteLt) fbk = FB_LT;
          else fbk = FB_OTHER;
          if (fbk == FB_DIGIT) take_param_byte(b);
        end else if (fbk == FB_DIGIT || fbk == FB_LT) begin
          take_param_byte(b);
        end
        // final byte, or the collector is full and takes this byte as final
        if ((b >= FinalLo && b <= FinalHi) || seq_len >= SeqMaxBytes) begin
          r = csi_final(b);
          drop_sequence();
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(input tekd_op_e op, input logic [7:0] b);
    feed_item_t it;
    it.op = op;
    it.b  = b;
    byte_feed.push_back(it);
    n_pushed++;
  endtask

  task automatic push_tick();
    push_item(OP_TICK, 8'($urandom));
  endtask

  // Random phases now and then slip a tick between the bytes of a sequence
  task automatic push_byte(input logic [7:0] b);
    if (jitter && $urandom_range(0, 49) == 0) push_tick();
    push_item(OP_BYTE, b);
  endtask

  task automatic push_num(input int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) push_num($urandom_range(4096, 99999));
    else if (k != 1) push_num($urandom_range(0, 300));
  endtask

  task automatic gen_random(input int count, input int thr);
    int stop_at, sel, k, n;
    stop_at = n_pushed + count;
    jitter  = 1'b1;
    while (n_pushed < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 14) begin
        k = $urandom_range(0, 255);
        push_byte((k == ByteEsc) ? 8'h00 : 8'(k));
      end else if (sel < 22) begin
        k = $urandom_range(0, 2);
        if (k == 0) push_byte(ByteDel);
        else if (k == 1) push_byte(ByteTab);
        else push_tick();
      end else if (sel < 37) begin
        // cursor keys, with or without parameters
        push_byte(ByteEsc);
        push_byte(ByteLbr);
        k = $urandom_range(0, 2);
        if (k == 1) push_num($urandom_range(0, 9));
        if (k == 2) begin
          push_num(1);
          push_byte(ByteSemi);
          push_num($urandom_range(2, 8));
        end
        case ($urandom_range(0, 5))
          0: push_byte(ByteUpA);
          1: push_byte(ByteUpB);
          2: push_byte(ByteUpC);
          3: push_byte(ByteUpD);
          4: push_byte(ByteUpH);
          default: push_byte(ByteUpF);
        endcase
      end else if (sel < 52) begin
        // tilde-coded editing and function keys
        push_byte(ByteEsc);
        push_byte(ByteLbr);
        k = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 30);
        else n = (k < 6) ? k + 1 : (k < 11) ? k + 5 : (k < 16) ? k + 6 : k + 7;
        push_num(n);
        if ($urandom_range(0, 3) == 0) begin
          push_byte(ByteSemi);
          push_num($urandom_range(2, 8));
        end
        push_byte(ByteTilde);
      end else if (sel < 67) begin
        // SGR mouse; sometimes short of fields or with an odd final
        push_byte(ByteEsc);
        push_byte(ByteLbr);
        push_byte(ByteLt);
        push_num($urandom_range(0, 127));
        push_byte(ByteSemi);
        push_coord();
        if ($urandom_range(0, 9) != 0) begin
          push_byte(ByteSemi);
          if ($urandom_range(0, 7) == 0) push_byte(ByteSemi);
          push_coord();
        end
        k = $urandom_range(0, 9);
        push_byte((k < 5) ? ByteUpM : (k < 9) ? 8'h6D : 8'($urandom_range(8'h40, 8'h7E)));
      end else if (sel < 74) begin
        push_byte(ByteEsc);
        push_byte(ByteSs3);
        case ($urandom_range(0, 6))
          0: push_byte(ByteUpP);
          1: push_byte(ByteUpQ);
          2: push_byte(ByteUpR);
          3: push_byte(ByteUpS);
          4: push_byte(ByteUpH);
          5: push_byte(ByteUpF);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end else if (sel < 82) begin
        // pending sequence left to time out, or nearly so
        push_byte(ByteEsc);
        k = $urandom_range(0, 2);
        if (k == 1) begin
          push_byte(ByteLbr);
          if ($urandom_range(0, 1) != 0) push_num($urandom_range(0, 99));
        end
        if (k == 2) push_byte(ByteSs3);
        n = thr - 1 + $urandom_range(0, 2);
        if (n < 1) n = 1;
        if (n > 48) n = 48;
        repeat (n) push_tick();
      end else if (sel < 92) begin
        // unterminated or overlong CSI bodies
        push_byte(ByteEsc);
        push_byte(ByteLbr);
        n = $urandom_range(1, 17);
        repeat (n) push_byte(8'($urandom_range(8'h20, 8'h3F)));
        if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(8'h40, 8'h7E)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) push_tick();
          else if ($urandom_range(0, 3) == 0) push_byte(ByteEsc);
          else push_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    jitter = 1'b0;
  endtask

  // Wait until every item is taken and every key has come out
  task automatic drain();
    do @(negedge clk_i); while (n_taken != n_pushed || pending_keys.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Timeout register write; called at a falling edge with the block idle
  task automatic write_timeout(input logic [TimeoutW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    feed_item_t it;
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (byte_feed.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        it = byte_feed.pop_front();
        in_valid <= 1'b1;
        in_op    <= it.op;
        in_byte  <= it.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls: random, plus two long hold-offs to fill the block
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && n_taken >= 320 + 80 * holds_done) begin
      holds_done++;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      if (n_err < 40) $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk_i) begin
    tekd_result_t want;
    tekd_result_t r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        tmo       = cfg_data;
        cfg_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (pending_keys.size() == 0) begin
          if (n_err < 40) $display("%0t: key %0d with nothing expected", $time, key_code);
          n_err++;
        end else begin
          want = pending_keys.pop_front();
          check_field("key_code", want.key, key_code);
          check_field("char_code", want.ch, char_code);
          check_field("mouse_button", want.btn, mouse_button);
          check_field("mouse_pressed", want.pressed, mouse_pressed);
          check_field("mouse_x", want.x, mouse_x);
          check_field("mouse_y", want.y, mouse_y);
        end
      end
      if (in_valid && !in_stall) begin
        n_taken++;
        in_taken = 1'b1;
        if (decode_key(tekd_op_e'(in_op), in_byte, r)) pending_keys.push_back(r);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("terminal_escape_key_decoder_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    drop_sequence();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, backspace, tab, idle tick, SS3, unknown after ESC,
    // tilde key, mouse with a saturating column
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(ByteDel);
    push_byte(ByteTab);
    push_item(OP_TICK, 8'hFF);
    push_byte(ByteEsc);
    push_byte(ByteSs3);
    push_byte(ByteUpP);
    push_byte(ByteEsc);
    push_byte(8'h78);
    push_byte(ByteEsc);
    push_byte(ByteLbr);
    push_num(24);
    push_byte(ByteTilde);
    push_byte(ByteEsc);
    push_byte(ByteLbr);
    push_byte(ByteLt);
    push_num(5);
    push_byte(ByteSemi);
    push_num(5000);
    push_byte(ByteSemi);
    push_num(4);
    push_byte(ByteUpM);
    drain();

    // Zero timeout acts as one tick
    write_timeout('0);
    push_byte(ByteEsc);
    push_tick();
    push_byte(ByteEsc);
    push_byte(ByteLbr);
    push_num(1);
    push_tick();
    drain();

    // Longest timeout, run out in full
    write_timeout(8'hFF);
    push_byte(ByteEsc);
    repeat (255) push_tick();
    drain();

    write_timeout(8'd3);
    gen_random(60, 3);
    drain();

    write_timeout(8'd1);
    gen_random(40, 1);
    drain();

    begin
      int t;
      t = $urandom_range(2, 40);
      write_timeout(8'(t));
      gen_random(60, t);
    end
    drain();

    if (n_err == 0 && pending_keys.size() == 0) begin
      $display("terminal_escape_key_decoder_top regression: pass");
    end else begin
      $display("terminal_escape_key_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tekd_pkg.sv
sv/tekd_parser.sv
sv/terminal_escape_key_decoder_top.sv
tb/sv/terminal_escape_key_decoder_top_tb.sv
